// ===== rtl/spe_pkg.sv =====
// Shared types, constants and control words for the shuffle permutation emitter.
package spe_pkg;

  localparam int unsigned FIELD_BITS     = 32;
  localparam int unsigned DRAW_BITS      = 10;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned EPOCH_BITS     = 8;
  localparam int unsigned DEF_MAX_SPAN   = 4096;
  localparam int unsigned DEF_VALUE_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_LOW    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 2'd2;

  localparam logic [FIELD_BITS-1:0] LOW_RST    = 32'd0;
  localparam logic [FIELD_BITS-1:0] HIGH_RST   = 32'd4095;
  localparam logic [DRAW_BITS-1:0]  THRESH_RST = 10'd0;

  typedef struct packed {
    logic                  start_run;
    logic [FIELD_BITS-1:0] partner_index;
    logic [DRAW_BITS-1:0]  skip_draw;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] perm_value;
    logic                  skipped;
    logic                  index_error;
    logic                  last;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic epoch_inc;
    logic sweep;
    logic calc;
    logic mod_start;
    logic mod_sel_i;
    logic rd_j;
    logic rd_i;
    logic latch_aj;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_flag;
    logic epoch_full;
    logic sweep_last;
    logic mod_done;
  } ctrl_sts_t;

endpackage

// ===== rtl/shuffle_permutation_emitter_top.sv =====
// Top level of the shuffle permutation emitter.
// An accepted word yields one result strobe; the next word is taken in the strobe cycle.
// When MAX_SPAN is not a power of two, the slot unit reduces 8 bits per cycle. Two store
// reads go through one read port. After reset the store sweep runs with busy high; a run
// start also sweeps the store once every 255 runs when the epoch tag wraps. Results cannot
// be stalled.
module shuffle_permutation_emitter_top #(
  parameter int unsigned MAX_SPAN   = spe_pkg::DEF_MAX_SPAN,
  parameter int unsigned VALUE_BITS = spe_pkg::DEF_VALUE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  spe_pkg::in_word_t                in_i,
  output logic                             out_valid_o,
  output spe_pkg::out_word_t               out_o,
  input  logic                             cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [spe_pkg::FIELD_BITS-1:0]   cfg_data_i
);
  import spe_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  spe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  spe_datapath #(
    .MAX_SPAN   (MAX_SPAN),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/spe_slot_mod.sv =====
// Slot reduction unit: offset modulo MAX_SPAN, mask for powers of two, else digit-serial.
module spe_slot_mod #(
  parameter int unsigned MAX_SPAN = spe_pkg::DEF_MAX_SPAN
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [spe_pkg::FIELD_BITS-1:0]       diff_i,
  output logic [$clog2(MAX_SPAN)-1:0]          slot_o,
  output logic                                 done_o
);
  import spe_pkg::*;

  localparam int unsigned SLOT_BITS = $clog2(MAX_SPAN);
  localparam bit          IS_POW2   = (MAX_SPAN & (MAX_SPAN - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      logic [SLOT_BITS-1:0] slot_q;
      logic                 done_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          slot_q <= diff_i[SLOT_BITS-1:0];
        end
      end

      assign slot_o = slot_q;
      assign done_o = done_q;
    end else begin : g_serial
      localparam int unsigned STEP     = 8;
      localparam int unsigned ROUNDS   = FIELD_BITS / STEP;
      localparam int unsigned CNT_BITS = $clog2(ROUNDS);
      localparam int unsigned RW       = SLOT_BITS + 1;
      localparam logic [RW-1:0]       SPAN_W   = RW'(MAX_SPAN);
      localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ROUNDS - 1);

      logic [SLOT_BITS-1:0]  rem_q, rem_d;
      logic [FIELD_BITS-1:0] shf_q;
      logic [CNT_BITS-1:0]   cnt_q;
      logic                  act_q;
      logic                  done_q;

      always_comb begin
        logic [RW-1:0] t;
        t     = '0;
        rem_d = rem_q;
        for (int k = 0; k < STEP; k++) begin
          t = {rem_d, shf_q[FIELD_BITS-1-k]};
          if (t >= SPAN_W) begin
            t = t - SPAN_W;
          end
          rem_d = t[SLOT_BITS-1:0];
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          act_q  <= 1'b0;
          done_q <= 1'b0;
          cnt_q  <= '0;
        end else begin
          done_q <= 1'b0;
          if (start_i) begin
            act_q <= 1'b1;
            cnt_q <= '0;
          end else if (act_q) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CNT_LAST) begin
              act_q  <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          rem_q <= '0;
          shf_q <= diff_i;
        end else if (act_q) begin
          rem_q <= rem_d;
          shf_q <= shf_q << STEP;
        end
      end

      assign slot_o = rem_q;
      assign done_o = done_q;
    end
  endgenerate

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(slot_o) < MAX_SPAN))
    else $error("slot out of range");

endmodule

// ===== rtl/spe_datapath.sv =====
// Datapath: configuration, position, epoch-tagged swap store, slot unit and result word.
module spe_datapath #(
  parameter int unsigned MAX_SPAN   = spe_pkg::DEF_MAX_SPAN,
  parameter int unsigned VALUE_BITS = spe_pkg::DEF_VALUE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [spe_pkg::FIELD_BITS-1:0]   cfg_data_i,
  input  spe_pkg::in_word_t                in_i,
  input  spe_pkg::ctrl_cmd_t               cmd_i,
  output spe_pkg::ctrl_sts_t               sts_o,
  output logic                             out_valid_o,
  output spe_pkg::out_word_t               out_o
);
  import spe_pkg::*;

  localparam int unsigned SLOT_BITS  = $clog2(MAX_SPAN);
  localparam int unsigned ENTRY_BITS = EPOCH_BITS + VALUE_BITS;
  localparam logic [SLOT_BITS-1:0]  SLOT_LAST = SLOT_BITS'(MAX_SPAN - 1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);

  logic [FIELD_BITS-1:0] low_q, high_q, pos_q;
  logic [DRAW_BITS-1:0]  thr_q;
  logic [EPOCH_BITS-1:0] epoch_q;
  logic [SLOT_BITS-1:0]  sweep_cnt_q, slot_j_q, mod_slot;
  in_word_t              in_q;
  logic [FIELD_BITS-1:0] jeff_q, jeff_c, diff_c;
  logic                  err_q, err_c, last_q;
  logic [VALUE_BITS-1:0] aj_q, ai_c, aj_c;
  logic [ENTRY_BITS-1:0] mem_q [MAX_SPAN];
  logic [ENTRY_BITS-1:0] rd_data_q;
  logic                  hit_c, mod_done;
  out_word_t             out_q;
  logic                  out_valid_q;

  assign err_c  = (in_q.partner_index < low_q) || (in_q.partner_index > pos_q);
  assign jeff_c = err_c ? pos_q : in_q.partner_index;
  assign diff_c = cmd_i.mod_sel_i ? (pos_q - low_q) : (jeff_c - low_q);

  spe_slot_mod #(
    .MAX_SPAN (MAX_SPAN)
  ) u_slot_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .diff_i  (diff_c),
    .slot_o  (mod_slot),
    .done_o  (mod_done)
  );

  assign hit_c = rd_data_q[ENTRY_BITS-1:VALUE_BITS] == epoch_q;
  assign aj_c  = hit_c ? rd_data_q[VALUE_BITS-1:0] : jeff_q[VALUE_BITS-1:0];
  assign ai_c  = hit_c ? rd_data_q[VALUE_BITS-1:0] : pos_q[VALUE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= LOW_RST;
      high_q      <= HIGH_RST;
      thr_q       <= THRESH_RST;
      pos_q       <= '0;
      epoch_q     <= EPOCH_ONE;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LOW:    low_q  <= cfg_data_i;
          REG_HIGH:   high_q <= cfg_data_i;
          REG_THRESH: thr_q  <= cfg_data_i[DRAW_BITS-1:0];
          default:    ;
        endcase
      end
      if (cmd_i.accept && in_i.start_run) begin
        pos_q <= high_q;
      end else if (cmd_i.finish && !last_q) begin
        pos_q <= pos_q - 1'b1;
      end
      if (cmd_i.sweep) begin
        sweep_cnt_q <= (sweep_cnt_q == SLOT_LAST) ? '0 : sweep_cnt_q + 1'b1;
        if (sweep_cnt_q == SLOT_LAST) begin
          epoch_q <= EPOCH_ONE;
        end
      end else if (cmd_i.epoch_inc) begin
        epoch_q <= epoch_q + 1'b1;
      end
      out_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mem_q[sweep_cnt_q] <= '0;
    end else if (cmd_i.finish) begin
      mem_q[slot_j_q] <= {epoch_q, ai_c};
    end
    if (cmd_i.rd_j || cmd_i.rd_i) begin
      rd_data_q <= mem_q[mod_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q <= in_i;
    end
    if (cmd_i.calc) begin
      jeff_q <= jeff_c;
      err_q  <= err_c;
      last_q <= pos_q <= low_q;
    end
    if (cmd_i.rd_j) begin
      slot_j_q <= mod_slot;
    end
    if (cmd_i.latch_aj) begin
      aj_q <= aj_c;
    end
    if (cmd_i.finish) begin
      out_q.perm_value  <= FIELD_BITS'(aj_q);
      out_q.skipped     <= in_q.skip_draw < thr_q;
      out_q.index_error <= err_q;
      out_q.last        <= last_q;
    end
  end

  assign sts_o.run_flag   = in_q.start_run;
  assign sts_o.epoch_full = &epoch_q;
  assign sts_o.sweep_last = sweep_cnt_q == SLOT_LAST;
  assign sts_o.mod_done   = mod_done;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |=> !out_valid_q)
    else $error("result strobe longer than one cycle");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch matches cleared tags");

endmodule

// ===== rtl/spe_ctrl.sv =====
// Controller: sequences store sweep, slot reductions, two reads and the write-back.
module spe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  spe_pkg::ctrl_sts_t  sts_i,
  output spe_pkg::ctrl_cmd_t  cmd_o
);
  import spe_pkg::*;

  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ARM    = 4'd2;
  localparam logic [3:0] S_RSWEEP = 4'd3;
  localparam logic [3:0] S_CALC   = 4'd4;
  localparam logic [3:0] S_WJ     = 4'd5;
  localparam logic [3:0] S_LJ     = 4'd6;
  localparam logic [3:0] S_WI     = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_ARM;
        end
      end
      S_ARM: begin
        if (sts_i.run_flag && sts_i.epoch_full) begin
          state_d = S_RSWEEP;
        end else begin
          cmd_o.epoch_inc = sts_i.run_flag;
          state_d         = S_CALC;
        end
      end
      S_RSWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc      = 1'b1;
        cmd_o.mod_start = 1'b1;
        state_d         = S_WJ;
      end
      S_WJ: begin
        if (sts_i.mod_done) begin
          cmd_o.rd_j = 1'b1;
          state_d    = S_LJ;
        end
      end
      S_LJ: begin
        cmd_o.latch_aj  = 1'b1;
        cmd_o.mod_start = 1'b1;
        cmd_o.mod_sel_i = 1'b1;
        state_d         = S_WI;
      end
      S_WI: begin
        cmd_o.mod_sel_i = 1'b1;
        if (sts_i.mod_done) begin
          cmd_o.rd_i = 1'b1;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != S_IDLE;

  a_accept_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_ARM))
    else $error("accepted word not armed");

  a_idle_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> ($past(state_q) == S_OUT || $past(state_q) == S_SWEEP))
    else $error("idle entered mid-word");

endmodule

// ===== tb/spe_checker.sv =====
// Checker for the shuffle permutation emitter: predicts each result word and compares it.
module spe_checker #(
  parameter int unsigned MAX_SPAN   = spe_pkg::DEF_MAX_SPAN,
  parameter int unsigned VALUE_BITS = spe_pkg::DEF_VALUE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  spe_pkg::in_word_t                in_i,
  input  logic                             out_valid_i,
  input  spe_pkg::out_word_t               out_i,
  input  logic                             cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [spe_pkg::FIELD_BITS-1:0]   cfg_data_i,
  output int unsigned                      fail_cnt_o,
  output int unsigned                      pending_o
);
  import spe_pkg::*;

  localparam logic [63:0]           ONE_SHIFT = 64'd1 << VALUE_BITS;
  localparam logic [FIELD_BITS-1:0] VAL_MASK  = FIELD_BITS'(ONE_SHIFT - 64'd1);

  logic [FIELD_BITS-1:0] low_q;
  logic [FIELD_BITS-1:0] high_q;
  logic [DRAW_BITS-1:0]  thresh_q;
  logic [FIELD_BITS-1:0] walk_pos;
  logic [FIELD_BITS-1:0] slot_val [MAX_SPAN];
  bit                    slot_vld [MAX_SPAN];
  out_word_t             predicted_perm [$];
  int unsigned           fail_cnt;
  int unsigned           pending_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_cnt;

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
  end

  function automatic int unsigned slot_of(input logic [FIELD_BITS-1:0] x);
    logic [FIELD_BITS-1:0] d;
    d = x - low_q;
    return d % MAX_SPAN;
  endfunction

  function automatic logic [FIELD_BITS-1:0] entry_at(input logic [FIELD_BITS-1:0] x);
    int unsigned s;
    s = slot_of(x);
    return slot_vld[s] ? slot_val[s] : x;
  endfunction

  task automatic clear_slots();
    int k;
    for (k = 0; k < MAX_SPAN; k++) slot_vld[k] = 1'b0;
  endtask

  task automatic swap_and_emit(input in_word_t w);
    logic [FIELD_BITS-1:0] pos;
    logic [FIELD_BITS-1:0] j;
    logic [FIELD_BITS-1:0] aj;
    logic [FIELD_BITS-1:0] ai;
    logic                  err;
    logic                  fin;
    int unsigned           s;
    out_word_t             r;
    if (w.start_run) begin
      clear_slots();
      walk_pos = high_q;
    end
    pos = walk_pos;
    j   = w.partner_index;
    err = !(j >= low_q && j <= pos);
    if (err) j = pos;
    aj = entry_at(j);
    ai = entry_at(pos);
    s = slot_of(j);
    slot_val[s] = ai;
    slot_vld[s] = 1'b1;
    fin = (pos <= low_q);
    if (!fin) walk_pos = pos - 1'b1;
    r.perm_value  = aj & VAL_MASK;
    r.skipped     = (w.skip_draw < thresh_q);
    r.index_error = err;
    r.last        = fin;
    predicted_perm.push_back(r);
  endtask

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      low_q    = LOW_RST;
      high_q   = HIGH_RST;
      thresh_q = THRESH_RST;
      walk_pos = '0;
      clear_slots();
      predicted_perm.delete();
    end else begin
      if (out_valid_i) begin
        if (predicted_perm.size() == 0) begin
          $error("result word with none pending: perm_value %0h", out_i.perm_value);
          fail_cnt++;
        end else begin
          exp_w = predicted_perm.pop_front();
          if (out_i.perm_value !== exp_w.perm_value) begin
            $error("perm_value expected %0h actual %0h", exp_w.perm_value, out_i.perm_value);
            fail_cnt++;
          end
          if (out_i.skipped !== exp_w.skipped) begin
            $error("skipped expected %0b actual %0b", exp_w.skipped, out_i.skipped);
            fail_cnt++;
          end
          if (out_i.index_error !== exp_w.index_error) begin
            $error("index_error expected %0b actual %0b", exp_w.index_error,
                   out_i.index_error);
            fail_cnt++;
          end
          if (out_i.last !== exp_w.last) begin
            $error("last expected %0b actual %0b", exp_w.last, out_i.last);
            fail_cnt++;
          end
        end
      end
      if (start_i && busy_i === 1'b0) swap_and_emit(in_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LOW: begin
            low_q = cfg_data_i;
          end
          REG_HIGH: begin
            high_q = cfg_data_i;
          end
          REG_THRESH: begin
            thresh_q = cfg_data_i[DRAW_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    pending_cnt = predicted_perm.size();
  end

endmodule

// ===== tb/shuffle_permutation_emitter_top_tb.sv =====
// Testbench top for the shuffle permutation emitter: stimulus, configuration and verdict.
module shuffle_permutation_emitter_top_tb;
  import spe_pkg::*;

  localparam int unsigned ITEM_TARGET = 700;
  localparam int unsigned CALM_AFTER  = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  in_word_t                in_word;
  logic                    out_valid;
  out_word_t               out_word;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [FIELD_BITS-1:0]   cfg_data;
  int unsigned             fail_cnt;
  int unsigned             pending_cnt;
  int unsigned             cycle_cnt;
  int unsigned             items_sent;
  logic [FIELD_BITS-1:0]   set_low;
  logic [FIELD_BITS-1:0]   set_high;
  logic [FIELD_BITS-1:0]   run_pos;

  shuffle_permutation_emitter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_o       (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  spe_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .in_i        (in_word),
    .out_valid_i (out_valid),
    .out_i       (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(input logic sr, input logic [FIELD_BITS-1:0] j,
                      input logic [DRAW_BITS-1:0] draw);
    in_word_t w;
    if (items_sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    w.start_run     = sr;
    w.partner_index = j;
    w.skip_draw     = draw;
    @(negedge clk_i);
    start   <= 1'b1;
    in_word <= w;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    if (sr) run_pos = set_high;
    if (run_pos > set_low) run_pos = run_pos - 1'b1;
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [FIELD_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic apply_setting(input logic [FIELD_BITS-1:0] lo,
                               input logic [FIELD_BITS-1:0] hi,
                               input logic [FIELD_BITS-1:0] th_data);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    while (busy !== 1'b0) @(negedge clk_i);
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    write_reg(REG_THRESH, th_data);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    set_low  = lo;
    set_high = hi;
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_partner(input logic [FIELD_BITS-1:0] pos);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82) return $urandom_range(pos, set_low);
    else if (r < 90) return $urandom;
    else if (r < 95) return pos + 1'b1;
    else return set_low - 1'b1;
  endfunction

  initial begin
    logic [FIELD_BITS-1:0] lo;
    logic [FIELD_BITS-1:0] hi;
    logic [FIELD_BITS-1:0] th;
    logic [FIELD_BITS-1:0] pos;
    logic [FIELD_BITS:0]   sum;
    logic                  sr;
    int unsigned           span;
    int unsigned           runs;
    int unsigned           run_len;
    int unsigned           r;
    int unsigned           k;

    rst_ni     = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    items_sent = 0;
    set_low    = LOW_RST;
    set_high   = HIGH_RST;
    run_pos    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (busy !== 1'b0) @(negedge clk_i);

    // before any run start, then a full-width run with edge partners and draws
    send(1'b0, 32'd0, 10'd0);
    send(1'b0, 32'd7, 10'd1023);
    send(1'b1, 32'd4095, 10'd999);
    send(1'b0, 32'd0, 10'd0);
    send(1'b0, 32'hFFFF_FFFF, 10'd500);
    send(1'b0, 32'd4093, 10'd1000);

    // short run to its end, then repeats at the last position
    apply_setting(32'd10, 32'd13, 32'hFFFF_FC00 | 32'd500);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    send(1'b1, 32'd12, 10'd499);
    send(1'b0, 32'd10, 10'd500);
    send(1'b0, 32'd11, 10'd501);
    send(1'b0, 32'd10, 10'd0);
    send(1'b0, 32'd10, 10'd3);
    send(1'b0, 32'd11, 10'd4);
    send(1'b1, 32'd9, 10'd0);

    // high below low
    apply_setting(32'd100, 32'd50, 32'd1000);
    send(1'b1, 32'd75, 10'd999);
    send(1'b0, 32'd50, 10'd1000);
    send(1'b0, 32'd100, 10'd1023);

    // span far wider than the store: shared slots
    apply_setting(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(1'b1, 32'hFFFF_FFFF, 10'd1022);
    send(1'b0, 32'hFFFF_EFFE, 10'd512);
    send(1'b0, 32'h0000_1FFE, 10'd0);
    send(1'b0, 32'hFFFF_FFFD, 10'd1);

    // values at the top of the range
    apply_setting(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd0);
    send(1'b1, 32'hFFFF_FFF0, 10'd0);
    send(1'b0, 32'hFFFF_FFFE, 10'd1);
    send(1'b0, 32'd0, 10'd2);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: lo = 32'd0;
        1: lo = $urandom_range(0, 5000);
        2: lo = $urandom;
        default: lo = 32'hFFFF_FFFF - $urandom_range(0, 50);
      endcase
      r = $urandom_range(0, 99);
      if (r < 80) begin
        span = $urandom_range(1, 24);
      end else if (r < 88) begin
        span = $urandom_range(2000, 4096);
      end else if (r < 94) begin
        span = 0;
      end else begin
        span = $urandom_range(4097, 100000);
      end
      if (span == 0) begin
        if (lo < 2) lo = lo + 32'd200;
        hi = lo - $urandom_range(1, 150);
      end else begin
        sum = {1'b0, lo} + span - 1;
        hi  = sum[FIELD_BITS] ? 32'hFFFF_FFFF : sum[FIELD_BITS-1:0];
      end
      case ($urandom_range(0, 5))
        0: th = 32'd0;
        1: th = 32'd1000;
        2: th = 32'd1023;
        default: th = $urandom_range(0, 1000);
      endcase
      th = FIELD_BITS'({$urandom, 10'd0}) | th;
      apply_setting(lo, hi, th);
      runs = $urandom_range(1, 3);
      for (k = 0; k < runs && items_sent < ITEM_TARGET; k++) begin
        if (hi >= lo && hi - lo < 64) run_len = hi - lo + 1 + $urandom_range(0, 3);
        else run_len = $urandom_range(4, 40);
        for (int n = 0; n < run_len; n++) begin
          sr  = (n == 0) || ($urandom_range(0, 99) < 3);
          pos = sr ? set_high : run_pos;
          send(sr, pick_partner(pos), $urandom_range(0, 1023));
        end
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spe_pkg.sv
rtl/spe_slot_mod.sv
rtl/spe_datapath.sv
rtl/spe_ctrl.sv
rtl/shuffle_permutation_emitter_top.sv
tb/spe_checker.sv
tb/shuffle_permutation_emitter_top_tb.sv
